@@ hdl/bda_pkg.sv @@
// Package for the binary to decimal ASCII converter.
// Holds field widths, digit count and the ASCII offset; no dependencies.
package bda_pkg;

  localparam int VALUE_W        = 32;   // width of the input field
  localparam int VALUE_BITS_DEF = 32;   // default number of bits converted
  localparam int BCD_DIGITS     = 10;   // decimal digits of a 32-bit number
  localparam int DIGIT_W        = 4;    // bits of one BCD digit
  localparam int CHAR_W         = 6;    // width of the character field
  localparam int POS_W          = $clog2(BCD_DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // Control handed from the sequencer to the row of digit cells
  typedef struct packed {
    logic clear;   // zero every digit
    logic shift;   // one add-3 and shift pass
  } cell_ctrl_t;

  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

@@ hdl/bda_in_if.sv @@
// Input channel of the converter: one binary number per item.
// Depends on bda_pkg for the field width.
interface bda_in_if import bda_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/bda_out_if.sv @@
// Output channel of the converter: one ASCII digit per item.
// Depends on bda_pkg for the field width.
interface bda_out_if import bda_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

@@ hdl/binary_to_decimal_ascii_top.sv @@
// Top level of the binary to decimal ASCII converter.
// Depends on bda_pkg, bda_in_if, bda_out_if and bda_chain.
//
//   port     | role   | payload
//   ---------+--------+------------------------------------------
//   value_ch | sink   | value[31:0], unsigned number
//   digit_ch | source | digit_char[5:0] ASCII digit, last_digit
//
// A number is accepted, shifted through the digit row in min(VALUE_BITS,32)
// passes and its leading digit is found, then one character is loaded per
// cycle while the output is not stalled.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register. A stalled output holds the current character and the
// sequencer; a new number is taken once the last character is loaded.
module binary_to_decimal_ascii_top import bda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  bda_in_if.sink    value_ch,
  bda_out_if.source digit_ch
);

  localparam int EFF_BITS = (VALUE_BITS > VALUE_W) ? VALUE_W : VALUE_BITS;
  localparam int CNT_W    = $clog2(EFF_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state;
  logic [EFF_BITS-1:0] work;
  logic [CNT_W-1:0]    cnt;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    lead_pos;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic                accept;
  logic                load;
  cell_ctrl_t          ctrl;
  digit_t              digits [BCD_DIGITS];

  assign value_ch.ready = (state == ST_IDLE);
  assign accept         = value_ch.valid && value_ch.ready;
  assign load           = (state == ST_EMIT) && (!out_valid || digit_ch.ready);

  assign ctrl.clear = accept;
  assign ctrl.shift = (state == ST_CONV);

  bda_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .serial_in (work[EFF_BITS-1]),
    .digits    (digits)
  );

  // Find the highest nonzero digit; zero gives the units position
  always_comb begin
    lead_pos = '0;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (digits[i] != '0) begin
        lead_pos = POS_W'(i);
      end
    end
  end

  // Sequence conversion and emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            work  <= value_ch.value[EFF_BITS-1:0];
            cnt   <= CNT_W'(EFF_BITS - 1);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          work <= work << 1;
          if (cnt == '0) begin
            state <= ST_COUNT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_COUNT: begin
          pos   <= lead_pos;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            if (pos == '0) begin
              state <= ST_IDLE;
            end else begin
              pos <= pos - POS_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the current character until taken, then load the next
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (digit_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= ASCII_ZERO + CHAR_W'(digits[pos]);
      out_last <= (pos == '0);
    end
  end

  assign digit_ch.valid      = out_valid;
  assign digit_ch.digit_char = out_char;
  assign digit_ch.last_digit = out_last;

endmodule

@@ hdl/bda_cell.sv @@
// One BCD digit cell of the double-dabble row.
// Depends on bda_pkg; takes a bit from its lower neighbour, passes one up.
module bda_cell import bda_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       carry_in,
  output logic       carry_out,
  output digit_t     digit
);

  digit_t adjusted;

  // Add three to a digit of five or more before the shift
  always_comb begin
    adjusted  = (digit >= DIGIT_W'(5)) ? digit + DIGIT_W'(3) : digit;
    carry_out = adjusted[DIGIT_W-1];
  end

  // Clear on a new item, shift in the neighbour's bit on each pass
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= {adjusted[DIGIT_W-2:0], carry_in};
    end
  end

endmodule

@@ hdl/bda_chain.sv @@
// Row of BCD digit cells, least significant digit at index 0.
// Depends on bda_pkg and bda_cell.
module bda_chain import bda_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       serial_in,
  output digit_t     digits [BCD_DIGITS]
);

  logic carry [BCD_DIGITS];

  assign carry[0] = serial_in;

  // Each cell feeds its top bit into the next; the top cell's carry is dropped
  for (genvar i = 0; i < BCD_DIGITS; i++) begin : g_cell
    if (i == BCD_DIGITS - 1) begin : g_top
      bda_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i]),
        .carry_out (),
        .digit     (digits[i])
      );
    end else begin : g_mid
      bda_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i]),
        .carry_out (carry[i+1]),
        .digit     (digits[i])
      );
    end
  end

endmodule
